// ===== design/cksc_pkg.sv =====
// ----------------------------------------------------------------------------
// cksc_pkg
// Shared types and constants for the case-insensitive keyword scanner:
// keyword text, keyword lengths, case-folding constants and cell control.
// ----------------------------------------------------------------------------
package cksc_pkg;

  localparam int HIST_DEPTH = 9;
  localparam int KW_COUNT   = 3;
  localparam int KW_MAXLEN  = 10;

  // Keyword text, first character at position 0, padded with zeros.
  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAXLEN] = '{
    '{8'h6F, 8'h66, 8'h66, 8'h65, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h69, 8'h6E, 8'h74, 8'h65, 8'h72, 8'h76, 8'h69, 8'h65, 8'h77, 8'h00},
    '{8'h61, 8'h73, 8'h73, 8'h69, 8'h67, 8'h6E, 8'h6D, 8'h65, 8'h6E, 8'h74}
  };
  localparam int KW_LEN [KW_COUNT] = '{5, 9, 10};

  // ASCII upper-case range and the distance to lower case.
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] FOLD_OFFSET  = 8'h20;

  // Control that every history cell sees in the same cycle.
  typedef struct packed {
    logic shift;  // a byte is entering the history
    logic clear;  // the field or message is closing
  } cksc_ctl_t;

endpackage

// ===== design/cksc_if.sv =====
// ----------------------------------------------------------------------------
// cksc_if
// Valid/ready channels of the scanner: text words in, verdict words out.
// ----------------------------------------------------------------------------
interface cksc_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       field_end;
  logic       message_end;

  modport source (output valid, output data_byte, output has_byte,
                  output field_end, output message_end, input ready);
  modport sink   (input valid, input data_byte, input has_byte,
                  input field_end, input message_end, output ready);
endinterface

interface cksc_verdict_if;
  logic valid;
  logic ready;
  logic high_value;

  modport source (output valid, output high_value, input ready);
  modport sink   (input valid, input high_value, output ready);
endinterface

// ===== design/cksc_cell.sv =====
// ----------------------------------------------------------------------------
// cksc_cell
// One stage of the folded-byte history. Holds a byte and its valid bit,
// passes them to the next older stage on a shift, and narrows the running
// keyword match with its own character compare.
// ----------------------------------------------------------------------------
module cksc_cell
  import cksc_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  cksc_ctl_t           ctl,
  input  logic [7:0]          din,
  input  logic                valid_in,
  input  logic [KW_COUNT-1:0] match_in,
  output logic [7:0]          dout,
  output logic                valid_out,
  output logic [KW_COUNT-1:0] match_out
);

  logic [7:0] hist_byte;
  logic       valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      hist_byte <= din;
    end
  end

  assign dout      = hist_byte;
  assign valid_out = valid;

  // A keyword needs this stage only if it is longer than IDX + 1 characters.
  for (genvar k = 0; k < KW_COUNT; k++) begin : g_kw
    localparam int LEN = KW_LEN[k];
    if (IDX < LEN - 1) begin : g_used
      assign match_out[k] = match_in[k] & valid &
                            (hist_byte == KW_TEXT[k][LEN-2-IDX]);
    end else begin : g_pass
      assign match_out[k] = match_in[k];
    end
  end

endmodule

// ===== design/case_insensitive_keyword_scan.sv =====
// ----------------------------------------------------------------------------
// case_insensitive_keyword_scan
// Output: a verdict word is offered in the cycle after the message-end word is
//   accepted; behind a stalled output it waits in the skid register instead.
// Throughput: one text word per cycle; the folded byte is compared
//   combinationally against the nine-stage history chain; text stalls only
//   while the skid register holds a verdict.
// Reset (rst, synchronous): history, hit flag and output stages are emptied.
// ----------------------------------------------------------------------------
module case_insensitive_keyword_scan
  import cksc_pkg::*;
(
  input logic            clk,
  input logic            rst,
  cksc_text_if.sink      text,
  cksc_verdict_if.source verdict
);

  // Input handshake. The skid register absorbs one verdict while the output
  // register is stalled, so text can keep flowing until both are full.
  logic text_acc;
  logic skid_valid;
  assign text.ready = !skid_valid;
  assign text_acc   = text.valid && text.ready;

  // Case folding: only ASCII A-Z moves to lower case.
  logic [7:0] cur;
  always_comb begin
    if (text.data_byte >= CHAR_UPPER_A && text.data_byte <= CHAR_UPPER_Z) begin
      cur = text.data_byte + FOLD_OFFSET;
    end else begin
      cur = text.data_byte;
    end
  end

  // Control broadcast to the chain. Clearing wins over shifting, so a byte
  // on a closing word is matched but never kept.
  cksc_ctl_t ctl;
  assign ctl.shift = text_acc && text.has_byte;
  assign ctl.clear = text_acc && (text.field_end || text.message_end);

  // The incoming byte must equal the last character of each keyword; the
  // chain then checks the earlier characters, one per history stage.
  logic [KW_COUNT-1:0] chain [HIST_DEPTH+1];
  logic [7:0]          hist_byte [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] hist_valid;

  for (genvar k = 0; k < KW_COUNT; k++) begin : g_head
    assign chain[0][k] = (cur == KW_TEXT[k][KW_LEN[k]-1]);
  end

  for (genvar i = 0; i < HIST_DEPTH; i++) begin : g_cell
    logic [7:0] din;
    logic       valid_in;
    if (i == 0) begin : g_first
      assign din      = cur;
      assign valid_in = 1'b1;
    end else begin : g_rest
      assign din      = hist_byte[i-1];
      assign valid_in = hist_valid[i-1];
    end

    cksc_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .din       (din),
      .valid_in  (valid_in),
      .match_in  (chain[i]),
      .dout      (hist_byte[i]),
      .valid_out (hist_valid[i]),
      .match_out (chain[i+1])
    );
  end

  // Sticky hit flag across the fields of one message.
  logic hit;
  logic found;
  logic found_next;
  logic emit;
  logic verdict_val;

  assign hit         = ctl.shift && (|chain[HIST_DEPTH]);
  assign emit        = text_acc && text.message_end;
  assign verdict_val = found || hit;

  always_comb begin
    if (emit) begin
      found_next = 1'b0;
    end else begin
      found_next = found || hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else begin
      found <= found_next;
    end
  end

  // Output register plus skid register, oldest verdict always in front.
  logic out_valid;
  logic out_valid_next;
  logic out_val;
  logic out_val_next;
  logic skid_valid_next;
  logic skid_val;
  logic skid_val_next;

  always_comb begin
    out_valid_next  = out_valid;
    out_val_next    = out_val;
    skid_valid_next = skid_valid;
    skid_val_next   = skid_val;
    if (!out_valid || verdict.ready) begin
      if (skid_valid) begin
        out_valid_next  = 1'b1;
        out_val_next    = skid_val;
        skid_valid_next = emit;
        skid_val_next   = verdict_val;
      end else begin
        out_valid_next  = emit;
        out_val_next    = verdict_val;
      end
    end else if (emit) begin
      skid_valid_next = 1'b1;
      skid_val_next   = verdict_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      out_valid  <= out_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_val  <= out_val_next;
    skid_val <= skid_val_next;
  end

  assign verdict.valid      = out_valid;
  assign verdict.high_value = out_val;

`ifndef ASSERT_OFF
  // History stages fill from the newest end, so valid bits stay contiguous.
  a_hist_contig: assert property (@(posedge clk) disable iff (rst)
    (hist_valid & ~{hist_valid[HIST_DEPTH-2:0], 1'b1}) == '0)
    else $error("history valid bits are not contiguous");

  // A closed field leaves an empty history behind.
  a_field_clear: assert property (@(posedge clk) disable iff (rst)
    text_acc && text.field_end |=> hist_valid == '0)
    else $error("history not cleared after field end");

  // A message end resets the hit flag.
  a_found_clear: assert property (@(posedge clk) disable iff (rst)
    emit |=> !found)
    else $error("hit flag survived message end");

  // A verdict word is offered right after the message-end word.
  a_emit_shown: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid)
    else $error("verdict not presented after message end");

  // The skid register only fills behind a held output register.
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full with output register empty");
`endif

endmodule
